[src/frt_pkg.sv]
// Shared constants, types and status codes of the fragment reassembly tracker.
`timescale 1ns / 1ps
package frt_pkg;

  localparam int SLOT_COUNT   = 16;
  localparam int MAX_LENGTH   = 4096;
  localparam int HDR_MIN_LEN  = 5;
  localparam int HDR_BYTES    = 9;

  localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LEN_W     = 13;
  localparam int OFF_W     = 12;
  localparam int WR_W      = $clog2(MAX_LENGTH + 1);
  localparam int SUM_W     = ((WR_W > LEN_W) ? WR_W : LEN_W) + 1;
  localparam int HDR_IDX_W = $clog2(HDR_BYTES);
  localparam int HDR_W     = 8 * HDR_BYTES;

  typedef enum logic [2:0] {
    ST_TAKEN     = 3'd0,
    ST_CHUNK     = 3'd1,
    ST_DONE      = 3'd2,
    ST_BAD_SLOT  = 3'd3,
    ST_BAD_LEN   = 3'd4,
    ST_NOT_READY = 3'd5,
    ST_SHORT     = 3'd6,
    ST_CONSUMED  = 3'd7
  } status_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic                 consume;
    logic                 bad_slot;
    logic [SLOT_W-1:0]    slot;
    logic [LEN_W-1:0]     frag_total;
    logic [LEN_W-1:0]     seg_len;
    logic [LEN_W:0]       frag_end;
    logic                 bad_base;
    logic                 bad_idle;
    logic                 last_byte;
    logic                 hdr_hit;
    logic [HDR_IDX_W-1:0] hdr_idx;
    logic [7:0]           data_byte;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  msg_flags;
    logic [31:0] msg_kind;
    logic [31:0] payload_length;
  } res_t;

endpackage

[src/frt_front.sv]
// Front end: takes words, runs the slot-independent checks and queues them.
`timescale 1ns / 1ps
module frt_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_req_type,
  input  logic [7:0]                  in_stream_id,
  input  logic [frt_pkg::OFF_W-1:0]   in_frag_offset,
  input  logic [frt_pkg::LEN_W-1:0]   in_frag_total,
  input  logic [frt_pkg::LEN_W-1:0]   in_seg_len,
  input  logic [frt_pkg::OFF_W-1:0]   in_byte_index,
  input  logic [7:0]                  in_data_byte,
  output logic                        fq_valid,
  output frt_pkg::cmd_t               fq_head,
  input  logic                        fq_pop
);

  frt_pkg::cmd_t              cmd;
  logic [frt_pkg::LEN_W-1:0]  pos;
  logic [frt_pkg::LEN_W-1:0]  bidx;
  frt_pkg::cmd_t              q_r [2];
  logic                       wp_r, rp_r;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic                       push_ok, pop_ok;

  always_comb begin
    bidx = frt_pkg::LEN_W'(in_byte_index);
    pos  = frt_pkg::LEN_W'(in_frag_offset) + bidx;
    cmd.consume    = in_req_type;
    cmd.bad_slot   = {1'b0, in_stream_id} >= 9'(frt_pkg::SLOT_COUNT);
    cmd.slot       = in_stream_id[frt_pkg::SLOT_W-1:0];
    cmd.frag_total = in_frag_total;
    cmd.seg_len    = in_seg_len;
    cmd.frag_end   = (frt_pkg::LEN_W+1)'(in_frag_offset) + (frt_pkg::LEN_W+1)'(in_seg_len);
    cmd.bad_base   = (in_seg_len == '0) || (bidx >= in_seg_len);
    // an idle slot takes the word's own total, so all its checks are known here
    cmd.bad_idle   = cmd.bad_base || (in_frag_total == '0)
                     || (frt_pkg::SUM_W'(in_frag_total) > frt_pkg::SUM_W'(frt_pkg::MAX_LENGTH))
                     || (in_seg_len > in_frag_total)
                     || (cmd.frag_end > (frt_pkg::LEN_W+1)'(in_frag_total));
    cmd.last_byte  = bidx == (in_seg_len - frt_pkg::LEN_W'(1));
    cmd.hdr_hit    = pos < frt_pkg::LEN_W'(frt_pkg::HDR_BYTES);
    cmd.hdr_idx    = pos[frt_pkg::HDR_IDX_W-1:0];
    cmd.data_byte  = in_data_byte;
  end

  assign in_full  = cnt_r == 2'd2;
  assign fq_valid = cnt_r != 2'd0;
  assign fq_head  = q_r[rp_r];
  assign push_ok  = in_push && !in_full;
  assign pop_ok   = fq_pop && fq_valid;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= !wp_r;
      if (pop_ok)  rp_r <= !rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= cmd;
  end

  a_fq_depth: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("front queue over depth");

endmodule

[src/frt_back.sv]
// Back end: slot table update and result queue.
`timescale 1ns / 1ps
module frt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fq_valid,
  input  frt_pkg::cmd_t       fq_head,
  output logic                fq_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [2:0]          out_status,
  output logic [7:0]          out_msg_flags,
  output logic [31:0]         out_msg_kind,
  output logic [31:0]         out_payload_length
);

  logic                          act_r [frt_pkg::SLOT_COUNT];
  logic [frt_pkg::LEN_W-1:0]     tot_r [frt_pkg::SLOT_COUNT];
  logic [frt_pkg::WR_W-1:0]      wr_r  [frt_pkg::SLOT_COUNT];
  logic [frt_pkg::HDR_W-1:0]     hdr_r [frt_pkg::SLOT_COUNT];

  logic                          act_rd;
  logic [frt_pkg::LEN_W-1:0]     tot_rd;
  logic [frt_pkg::WR_W-1:0]      wr_rd;
  logic [frt_pkg::HDR_W-1:0]     hdr_rd;

  logic                          exec;
  logic                          upd;
  logic                          act_w;
  logic [frt_pkg::LEN_W-1:0]     tot_w;
  logic [frt_pkg::WR_W-1:0]      wr_w;
  logic [frt_pkg::HDR_W-1:0]     hdr_w;
  frt_pkg::res_t                 res;

  frt_pkg::res_t                 oq_r [2];
  logic                          owp_r, orp_r;
  logic [1:0]                    ocnt_r;
  logic                          opop_ok;

  assign act_rd = act_r[fq_head.slot];
  assign tot_rd = tot_r[fq_head.slot];
  assign wr_rd  = wr_r[fq_head.slot];
  assign hdr_rd = hdr_r[fq_head.slot];

  assign exec   = fq_valid && (ocnt_r != 2'd2);
  assign fq_pop = exec;

  always_comb begin
    logic                       bad;
    logic [frt_pkg::LEN_W-1:0]  tot_use;
    logic [frt_pkg::WR_W-1:0]   wr_base;
    logic [frt_pkg::SUM_W-1:0]  sum;
    res   = '{status: frt_pkg::ST_TAKEN, msg_flags: 8'd0, msg_kind: 32'd0,
              payload_length: 32'd0};
    upd   = 1'b0;
    act_w = 1'b0;
    tot_w = '0;
    wr_w  = '0;
    hdr_w = '0;
    bad   = 1'b0;
    tot_use = act_rd ? tot_rd : fq_head.frag_total;
    wr_base = act_rd ? wr_rd : '0;
    sum     = frt_pkg::SUM_W'(wr_base) + frt_pkg::SUM_W'(fq_head.seg_len);
    priority if (fq_head.bad_slot) begin
      res.status = frt_pkg::ST_BAD_SLOT;
    end else if (fq_head.consume) begin
      if (!act_rd || (frt_pkg::SUM_W'(wr_rd) < frt_pkg::SUM_W'(tot_rd))) begin
        res.status = frt_pkg::ST_NOT_READY;
      end else if (tot_rd < frt_pkg::LEN_W'(frt_pkg::HDR_MIN_LEN)) begin
        res.status = frt_pkg::ST_SHORT;
        upd        = 1'b1;
      end else begin
        res.status         = frt_pkg::ST_CONSUMED;
        res.msg_flags      = hdr_rd[7:0];
        res.msg_kind       = hdr_rd[39:8];
        res.payload_length = hdr_rd[71:40];
        upd                = 1'b1;
      end
    end else begin
      // an open slot checks against its stored total and ignores the word's own
      bad = act_rd ? (fq_head.bad_base || (fq_head.seg_len > tot_rd)
                      || (fq_head.frag_end > (frt_pkg::LEN_W+1)'(tot_rd)))
                   : fq_head.bad_idle;
      if (bad) begin
        res.status = frt_pkg::ST_BAD_LEN;
      end else begin
        upd   = 1'b1;
        act_w = 1'b1;
        tot_w = tot_use;
        wr_w  = wr_base;
        hdr_w = act_rd ? hdr_rd : '0;
        for (int i = 0; i < frt_pkg::HDR_BYTES; i++) begin
          if (fq_head.hdr_hit && (fq_head.hdr_idx == frt_pkg::HDR_IDX_W'(i)))
            hdr_w[8*i +: 8] = fq_head.data_byte;
        end
        if (fq_head.last_byte) begin
          // saturate the written count at the largest length
          if (sum > frt_pkg::SUM_W'(frt_pkg::MAX_LENGTH))
            sum = frt_pkg::SUM_W'(frt_pkg::MAX_LENGTH);
          wr_w       = sum[frt_pkg::WR_W-1:0];
          res.status = (sum >= frt_pkg::SUM_W'(tot_use)) ? frt_pkg::ST_DONE
                                                         : frt_pkg::ST_CHUNK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < frt_pkg::SLOT_COUNT; s++) begin
        act_r[s] <= 1'b0;
        tot_r[s] <= '0;
        wr_r[s]  <= '0;
        hdr_r[s] <= '0;
      end
    end else if (exec && upd) begin
      act_r[fq_head.slot] <= act_w;
      tot_r[fq_head.slot] <= tot_w;
      wr_r[fq_head.slot]  <= wr_w;
      hdr_r[fq_head.slot] <= hdr_w;
    end
  end

  // result queue: every executed word leaves exactly one result
  assign out_empty          = ocnt_r == 2'd0;
  assign opop_ok            = out_pop && !out_empty;
  assign out_status         = oq_r[orp_r].status;
  assign out_msg_flags      = oq_r[orp_r].msg_flags;
  assign out_msg_kind       = oq_r[orp_r].msg_kind;
  assign out_payload_length = oq_r[orp_r].payload_length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (exec)    owp_r <= !owp_r;
      if (opop_ok) orp_r <= !orp_r;
      ocnt_r <= ocnt_r + {1'b0, exec} - {1'b0, opop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (exec) oq_r[owp_r] <= res;
  end

  a_oq_depth: assert property (@(posedge clk) disable iff (!rst_n) ocnt_r <= 2'd2)
    else $error("result queue over depth");

  a_open_total: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && !fq_head.bad_slot && act_rd) |-> (tot_rd != '0))
    else $error("open slot with zero total");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && !fq_head.bad_slot && !act_rd) |-> ((wr_rd == '0) && (hdr_rd == '0)))
    else $error("idle slot holds stale state");

  a_consume_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && (res.status == frt_pkg::ST_CONSUMED))
      |-> (act_rd && (frt_pkg::SUM_W'(wr_rd) >= frt_pkg::SUM_W'(tot_rd))))
    else $error("consume of an incomplete slot");

endmodule

[src/fragment_reassembly_tracker.sv]
// Top level of the fragment reassembly tracker: front classifier and back slot table.
//
//   channel  direction  handshake        fields
//   in_      input      in_push/in_full  req_type stream_id frag_offset frag_total
//                                        seg_len byte_index data_byte
//   out_     output     out_pop/out_empty status msg_flags msg_kind payload_length
//
// One word per cycle sustained while out_pop keeps the result queue from filling; a
// word's result reaches out_ through the front queue register, then the result queue.
// Two-entry queues sit between the front and back and on the result side.
// rst_n (synchronous) frees every slot and empties both queues.
// A full result queue stalls the back; the front keeps taking words until its queue fills.
`timescale 1ns / 1ps
module fragment_reassembly_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_req_type,
  input  logic [7:0]                  in_stream_id,
  input  logic [frt_pkg::OFF_W-1:0]   in_frag_offset,
  input  logic [frt_pkg::LEN_W-1:0]   in_frag_total,
  input  logic [frt_pkg::LEN_W-1:0]   in_seg_len,
  input  logic [frt_pkg::OFF_W-1:0]   in_byte_index,
  input  logic [7:0]                  in_data_byte,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [2:0]                  out_status,
  output logic [7:0]                  out_msg_flags,
  output logic [31:0]                 out_msg_kind,
  output logic [31:0]                 out_payload_length
);

  logic          fq_valid;
  logic          fq_pop;
  frt_pkg::cmd_t fq_head;

  frt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_stream_id   (in_stream_id),
    .in_frag_offset (in_frag_offset),
    .in_frag_total  (in_frag_total),
    .in_seg_len     (in_seg_len),
    .in_byte_index  (in_byte_index),
    .in_data_byte   (in_data_byte),
    .fq_valid       (fq_valid),
    .fq_head        (fq_head),
    .fq_pop         (fq_pop)
  );

  frt_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .fq_valid           (fq_valid),
    .fq_head            (fq_head),
    .fq_pop             (fq_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_status         (out_status),
    .out_msg_flags      (out_msg_flags),
    .out_msg_kind       (out_msg_kind),
    .out_payload_length (out_payload_length)
  );

endmodule
